@@ hw/rtl/fta_pkg.sv @@
// ----------------------------------------------------------------------------
// fta_pkg
// Shared types and constants of the truncating single-precision ALU.
// ----------------------------------------------------------------------------
package fta_pkg;

  // operation codes
  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  // status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_NAN   = 2'd2,
    ST_DIVZ  = 2'd3
  } status_e;

  localparam int unsigned MantW  = 24;
  localparam int unsigned FracW  = 23;
  localparam int unsigned ExpW   = 11;
  localparam int unsigned MagW   = 32;
  localparam int unsigned DvsW   = 9;
  localparam int unsigned QuoW   = 24;
  localparam int unsigned NumW   = 24;
  localparam int unsigned DivStepsPerStage = 6;
  localparam int unsigned DivStages        = QuoW / DivStepsPerStage;
  localparam int unsigned Bias   = 127;
  localparam int unsigned ExpTop = 255;

  // word moving through the middle of the pipeline
  typedef struct packed {
    logic                   dz;
    logic                   is_div;
    logic                   sgn;
    logic signed [ExpW-1:0] exp;
    logic [MagW-1:0]        mag;
  } ctl_t;

  // normalized word before the range check
  typedef struct packed {
    logic                   dz;
    logic                   zero;
    logic                   sgn;
    logic signed [ExpW-1:0] exp;
    logic [FracW-1:0]       frac;
  } norm_t;

endpackage

@@ hw/rtl/fta_div_stage.sv @@
// ----------------------------------------------------------------------------
// fta_div_stage
// One registered slice of the restoring divider, a few quotient bits each.
// ----------------------------------------------------------------------------
module fta_div_stage (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [fta_pkg::DvsW-1:0]    rem_i,
  input  logic [fta_pkg::QuoW-1:0]    quo_i,
  input  logic [fta_pkg::NumW-1:0]    num_i,
  input  logic [fta_pkg::DvsW-1:0]    dvs_i,
  output logic [fta_pkg::DvsW-1:0]    rem_o,
  output logic [fta_pkg::QuoW-1:0]    quo_o,
  output logic [fta_pkg::NumW-1:0]    num_o,
  output logic [fta_pkg::DvsW-1:0]    dvs_o
);

  logic [fta_pkg::DvsW-1:0] rem_d;
  logic [fta_pkg::QuoW-1:0] quo_d;
  logic [fta_pkg::NumW-1:0] num_d;

  // shift in one dividend bit per step, subtract when it fits
  always_comb begin
    logic [fta_pkg::DvsW:0] t;
    t     = '0;
    rem_d = rem_i;
    quo_d = quo_i;
    num_d = num_i;
    for (int i = 0; i < int'(fta_pkg::DivStepsPerStage); i++) begin
      t     = {rem_d, num_d[fta_pkg::NumW-1]};
      num_d = {num_d[fta_pkg::NumW-2:0], 1'b0};
      if (t >= {1'b0, dvs_i}) begin
        t     = t - {1'b0, dvs_i};
        quo_d = {quo_d[fta_pkg::QuoW-2:0], 1'b1};
      end else begin
        quo_d = {quo_d[fta_pkg::QuoW-2:0], 1'b0};
      end
      rem_d = t[fta_pkg::DvsW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o <= rem_d;
      quo_o <= quo_d;
      num_o <= num_d;
      dvs_o <= dvs_i;
    end
  end

endmodule

@@ hw/rtl/fta_norm.sv @@
// ----------------------------------------------------------------------------
// fta_norm
// Leading-one search, truncating normalize and rebias, registered.
// ----------------------------------------------------------------------------
module fta_norm (
  input  logic           clk_i,
  input  logic           en_i,
  input  fta_pkg::ctl_t  ctl_i,
  output fta_pkg::norm_t norm_o
);

  logic [4:0]                      lz;
  logic [fta_pkg::MagW-1:0]        shifted;
  fta_pkg::norm_t                  norm_d;

  // count leading zeros of the magnitude
  always_comb begin
    logic found;
    found = 1'b0;
    lz    = '0;
    for (int i = fta_pkg::MagW - 1; i >= 0; i--) begin
      if (!found && ctl_i.mag[i]) begin
        lz    = 5'(fta_pkg::MagW - 1 - i);
        found = 1'b1;
      end
    end
  end

  // leading one to bit 31, fraction sits just below it
  always_comb begin
    shifted       = ctl_i.mag << lz;
    norm_d.dz     = ctl_i.dz;
    norm_d.zero   = (ctl_i.mag == '0);
    norm_d.sgn    = ctl_i.sgn;
    norm_d.frac   = shifted[fta_pkg::MagW-2 -: fta_pkg::FracW];
    norm_d.exp    = ctl_i.exp + fta_pkg::ExpW'(fta_pkg::Bias + 8)
                    - $signed({{(fta_pkg::ExpW-5){1'b0}}, lz});
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      norm_o <= norm_d;
    end
  end

endmodule

@@ hw/rtl/float32_truncating_alu.sv @@
// ----------------------------------------------------------------------------
// float32_truncating_alu
// Single-precision add, subtract, multiply and divide with truncation.
// ----------------------------------------------------------------------------
// Fully pipelined: one word enters per cycle while the output does not stall,
// and each result passes through the stages decode, align/add or multiply
// with the first divide slice, three more divide slices, normalize and pack.
// The restoring divider of 24 quotient bits, six bits per stage, sets the depth.
// A stall at the output holds the whole pipeline; in_ready_o is low only
// while the output word waits and out_ready_i is low.
module float32_truncating_alu (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  req_type_i,
  input  logic [31:0] operand_a_i,
  input  logic [31:0] operand_b_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] result_word_o,
  output logic [1:0]  status_code_o
);

  localparam int unsigned NS = fta_pkg::DivStages;

  logic en;

  // stage 1: decoded operands
  logic                          v1_q;
  fta_pkg::op_e                  op_q;
  logic signed [9:0]             ea_q, eb_q;
  logic [fta_pkg::MantW-1:0]     ma_q, mb_q;
  logic                          sa_q, sb_q, dz_q;

  // middle stages
  logic          v_q   [NS];
  fta_pkg::ctl_t ctl_q [NS];
  fta_pkg::ctl_t ctl_d;
  fta_pkg::ctl_t ctl_fin;

  logic [fta_pkg::DvsW-1:0] rem [NS+1];
  logic [fta_pkg::QuoW-1:0] quo [NS+1];
  logic [fta_pkg::NumW-1:0] num [NS+1];
  logic [fta_pkg::DvsW-1:0] dvs [NS+1];

  logic           v6_q;
  fta_pkg::norm_t norm;

  logic        out_vld_q;
  logic [31:0] word_q;
  logic [1:0]  status_q;

  assign en         = !out_vld_q || out_ready_i;
  assign in_ready_o = en;

  // stage 1: unpack fields, effective sign of b, divide-by-zero check
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      op_q <= fta_pkg::op_e'(req_type_i);
      ea_q <= $signed({2'b00, operand_a_i[30:23]}) - 10'sd127;
      eb_q <= $signed({2'b00, operand_b_i[30:23]}) - 10'sd127;
      ma_q <= {1'b1, operand_a_i[22:0]};
      mb_q <= {1'b1, operand_b_i[22:0]};
      sa_q <= operand_a_i[31];
      sb_q <= operand_b_i[31] ^ (fta_pkg::op_e'(req_type_i) == fta_pkg::OP_SUB);
      dz_q <= (fta_pkg::op_e'(req_type_i) == fta_pkg::OP_DIV)
              && (operand_b_i[30:0] == 31'd0);
    end
  end

  // stage 2: align and add, or multiply; for divide only the exponent difference
  always_comb begin
    logic signed [9:0]         ediff;
    logic signed [9:0]         ndiff;
    logic [8:0]                shamt;
    logic                      a_gt;
    logic [fta_pkg::MantW-1:0] lo_mant, shf, ma_al, mb_al;
    logic [47:0]               prod;
    ediff   = ea_q - eb_q;
    ndiff   = eb_q - ea_q;
    a_gt    = ediff > 10'sd0;
    shamt   = a_gt ? ediff[8:0] : ndiff[8:0];
    lo_mant = a_gt ? mb_q : ma_q;
    shf     = (shamt >= 9'd32) ? '0 : lo_mant >> shamt[4:0];
    ma_al   = a_gt ? ma_q : shf;
    mb_al   = a_gt ? shf : mb_q;
    prod    = 48'(ma_q) * 48'(mb_q);

    ctl_d.dz     = dz_q;
    ctl_d.is_div = (op_q == fta_pkg::OP_DIV);
    ctl_d.sgn    = sa_q ^ sb_q;
    ctl_d.exp    = '0;
    ctl_d.mag    = '0;
    case (op_q)
      fta_pkg::OP_ADD, fta_pkg::OP_SUB: begin
        ctl_d.exp = a_gt ? 11'(ea_q) : 11'(eb_q);
        if (sa_q == sb_q) begin
          ctl_d.mag = 32'(ma_al) + 32'(mb_al);
          ctl_d.sgn = sa_q;
        end else if (ma_al > mb_al) begin
          ctl_d.mag = 32'(ma_al - mb_al);
          ctl_d.sgn = sa_q;
        end else begin
          ctl_d.mag = 32'(mb_al - ma_al);
          ctl_d.sgn = sb_q;
        end
      end
      fta_pkg::OP_MUL: begin
        ctl_d.exp = 11'(ea_q) + 11'(eb_q);
        ctl_d.mag = 32'(prod[47:23]);
      end
      fta_pkg::OP_DIV: begin
        ctl_d.exp = 11'(ea_q) - 11'(eb_q);
      end
      default: ;
    endcase
  end

  // divider: (ma << 8) / (mb >> 15), top byte seeds the remainder
  assign rem[0] = {1'b0, ma_q[23:16]};
  assign quo[0] = '0;
  assign num[0] = {ma_q[15:0], 8'd0};
  assign dvs[0] = mb_q[23:15];

  for (genvar k = 0; k < NS; k++) begin : g_div
    fta_div_stage u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .rem_i (rem[k]),
      .quo_i (quo[k]),
      .num_i (num[k]),
      .dvs_i (dvs[k]),
      .rem_o (rem[k+1]),
      .quo_o (quo[k+1]),
      .num_o (num[k+1]),
      .dvs_o (dvs[k+1])
    );
  end

  // stages 2 to 5: carry the word beside the divider
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < int'(NS); k++) v_q[k] <= 1'b0;
    end else if (en) begin
      v_q[0] <= v1_q;
      for (int k = 1; k < int'(NS); k++) v_q[k] <= v_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ctl_q[0] <= ctl_d;
      for (int k = 1; k < int'(NS); k++) ctl_q[k] <= ctl_q[k-1];
    end
  end

  always_comb begin
    ctl_fin = ctl_q[NS-1];
    if (ctl_q[NS-1].is_div) begin
      ctl_fin.mag = 32'(quo[NS]);
    end
  end

  // stage 6: normalize
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q <= 1'b0;
    end else if (en) begin
      v6_q <= v_q[NS-1];
    end
  end

  fta_norm u_norm (
    .clk_i  (clk_i),
    .en_i   (en),
    .ctl_i  (ctl_fin),
    .norm_o (norm)
  );

  // stage 7: range check and pack into the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= v6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (norm.dz) begin
        word_q   <= '0;
        status_q <= fta_pkg::ST_DIVZ;
      end else if (norm.zero) begin
        word_q   <= '0;
        status_q <= fta_pkg::ST_OK;
      end else if (norm.exp < 11'sd0 || norm.exp > 11'sd255) begin
        word_q   <= '0;
        status_q <= fta_pkg::ST_RANGE;
      end else if (norm.exp == 11'sd255 && norm.frac != '0) begin
        word_q   <= '0;
        status_q <= fta_pkg::ST_NAN;
      end else begin
        word_q   <= {norm.sgn, norm.exp[7:0], norm.frac};
        status_q <= fta_pkg::ST_OK;
      end
    end
  end

  assign out_valid_o   = out_vld_q;
  assign result_word_o = word_q;
  assign status_code_o = status_q;

endmodule
